### src/u8sd_pkg.sv
// Shared types, constants and the lead-byte classifier for the UTF-8 stream decoder.
// No dependencies; imported by every module of the decoder.
package u8sd_pkg;

  localparam int unsigned CP_W     = 31;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned IN_W     = 8;
  localparam int unsigned OUT_W    = 40;  // codepoint, byte_count, status, zero fill
  localparam int unsigned Q_DEPTH  = 4;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LEAD_ASCII,
    LEAD_SEQ,
    LEAD_BAD
  } lead_kind_t;

  typedef struct packed {
    lead_kind_t       kind;
    logic [CNT_W-1:0] len;
    logic [6:0]       bits;
  } lead_t;

  typedef struct packed {
    logic [CP_W-1:0]  codepoint;
    logic [CNT_W-1:0] byte_count;
    status_t          status;
  } result_t;

  // One queue entry: the results caused by one input item (one or two).
  typedef struct packed {
    result_t first;
    logic    has_second;
    result_t second;
  } entry_t;

  function automatic lead_t lead_decode(input logic [IN_W-1:0] b);
    lead_t l;
    l.kind = LEAD_BAD;
    l.len  = '0;
    l.bits = '0;
    case (b) inside
      [8'h00:8'h7F]: begin
        l.kind = LEAD_ASCII;
        l.len  = 3'd1;
        l.bits = b[6:0];
      end
      [8'hC0:8'hDF]: begin
        l.kind = LEAD_SEQ;
        l.len  = 3'd2;
        l.bits = {2'b0, b[4:0]};
      end
      [8'hE0:8'hEF]: begin
        l.kind = LEAD_SEQ;
        l.len  = 3'd3;
        l.bits = {3'b0, b[3:0]};
      end
      [8'hF0:8'hF4]: begin
        l.kind = LEAD_SEQ;
        l.len  = 3'd4;
        l.bits = {4'b0, b[2:0]};
      end
      [8'hF8:8'hFB]: begin
        l.kind = LEAD_SEQ;
        l.len  = 3'd5;
        l.bits = {5'b0, b[1:0]};
      end
      [8'hFC:8'hFD]: begin
        l.kind = LEAD_SEQ;
        l.len  = 3'd6;
        l.bits = {6'b0, b[0]};
      end
      default: begin
        l.kind = LEAD_BAD;
      end
    endcase
    return l;
  endfunction

  // Result for a byte handled as a lead that does not open a sequence.
  function automatic result_t lead_result(input lead_t l);
    result_t r;
    if (l.kind == LEAD_ASCII) begin
      r.codepoint  = {{(CP_W-7){1'b0}}, l.bits};
      r.byte_count = l.len;
      r.status     = ST_OK;
    end else begin
      r.codepoint  = '0;
      r.byte_count = '0;
      r.status     = ST_BAD_LEAD;
    end
    return r;
  endfunction

endpackage

### src/u8sd_front.sv
// Front end: accepts bytes, tracks the open sequence and queues the results per byte.
// Depends on u8sd_pkg.
module u8sd_front
  import u8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_byte,
  output logic            push,
  output entry_t          push_entry,
  input  logic            q_full
);

  logic [CNT_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [CNT_W-1:0] sequence_length, sequence_length_next;
  logic [CP_W-1:0]  partial_code, partial_code_next;
  logic             accept;
  logic             has_result;
  lead_t            lead;
  logic             is_cont;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign lead     = lead_decode(in_byte);
  assign is_cont  = (in_byte[7:6] == 2'b10);

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    partial_code_next    = partial_code;
    has_result           = 1'b0;
    push_entry           = '0;
    push_entry.first     = lead_result(lead);
    push_entry.second    = lead_result(lead);
    if (bytes_remaining == '0) begin
      if (lead.kind == LEAD_SEQ) begin
        sequence_length_next = lead.len;
        bytes_remaining_next = lead.len - 3'd1;
        partial_code_next    = {{(CP_W-7){1'b0}}, lead.bits};
      end else begin
        has_result = 1'b1;
      end
    end else if (is_cont) begin
      partial_code_next    = {partial_code[CP_W-7:0], in_byte[5:0]};
      bytes_remaining_next = bytes_remaining - 3'd1;
      if (bytes_remaining == 3'd1) begin
        has_result                  = 1'b1;
        push_entry.first.codepoint  = partial_code_next;
        push_entry.first.byte_count = sequence_length;
        push_entry.first.status     = ST_OK;
        sequence_length_next        = '0;
      end
    end else begin
      // Drop the open sequence, then treat this byte as a new lead.
      has_result                  = 1'b1;
      push_entry.first.codepoint  = '0;
      push_entry.first.byte_count = '0;
      push_entry.first.status     = ST_BAD_CONT;
      bytes_remaining_next        = '0;
      sequence_length_next        = '0;
      if (lead.kind == LEAD_SEQ) begin
        sequence_length_next = lead.len;
        bytes_remaining_next = lead.len - 3'd1;
        partial_code_next    = {{(CP_W-7){1'b0}}, lead.bits};
      end else begin
        push_entry.has_second = 1'b1;
      end
    end
  end

  assign push = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      sequence_length <= '0;
      partial_code    <= '0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
      partial_code    <= partial_code_next;
    end
  end

endmodule

### src/u8sd_fifo.sv
// Short queue of per-byte result entries between the front and back ends.
// Depends on u8sd_pkg.
module u8sd_fifo
  import u8sd_pkg::*;
#(
  parameter int unsigned DEPTH = Q_DEPTH
)
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/u8sd_back.sv
// Back end: expands queued entries into result items behind an output register.
// Depends on u8sd_pkg.
module u8sd_back
  import u8sd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  entry_t  q_head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result,
  output logic    out_last
);

  logic second_pending;
  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = load && !q_empty && (second_pending || !q_head.has_second);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        second_pending <= !second_pending && q_head.has_second;
      end
    end
  end

  // Hold the payload while the result waits; load the next one when free.
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      if (second_pending) begin
        out_result <= q_head.second;
        out_last   <= 1'b1;
      end else begin
        out_result <= q_head.first;
        out_last   <= !q_head.has_second;
      end
    end
  end

endmodule

### src/utf8_stream_decoder.sv
// Top level of the six-byte UTF-8 stream decoder: front end, result queue, back end.
// Depends on u8sd_pkg, u8sd_front, u8sd_fifo and u8sd_back.
//
//   channel  direction  contents
//   s_*      in         one raw byte per item
//   m_*      out        codepoint, byte_count, status; tlast on final result of a byte
//
// One byte is accepted per cycle while the queue has room; a byte yields zero, one
// or two result items, the two-result case (bad continuation followed by ASCII or
// bad lead) being held as one queue entry and sent as two output items. An accepted
// byte's result passes through the queue write, then the output register. Reset is
// synchronous and leaves the decoder idle awaiting a lead byte. s_tready drops only
// when the queue of QUEUE_DEPTH entries is full; m_tready stalls only the back end.
module utf8_stream_decoder
  import u8sd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = Q_DEPTH
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [30:0] codepoint, [33:31] byte_count,
                                      // [35:34] status, [39:36] zero
  output logic             m_tlast
);

  logic    push, q_full, q_empty, pop;
  entry_t  push_entry, q_head;
  result_t out_result;

  u8sd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  u8sd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  u8sd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result),
    .out_last   (m_tlast)
  );

  assign m_tdata = {4'b0, out_result.status, out_result.byte_count, out_result.codepoint};

endmodule
